FILE: rtl/mitu_pkg.sv
// Shared types, register map, constants and tables of the interrupt and timer unit.
package mitu_pkg;

    localparam int CLOCK_STEP_MAX_DEFAULT = 4095;
    localparam int REG_COUNT  = 24;
    localparam int DIVIDEND_W = 13;
    localparam int DIVISOR_W  = 9;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    localparam logic [2:0] KIND_READ    = 3'd0;
    localparam logic [2:0] KIND_WRITE   = 3'd1;
    localparam logic [2:0] KIND_REQUEST = 3'd2;
    localparam logic [2:0] KIND_ACK     = 3'd3;
    localparam logic [2:0] KIND_ADVANCE = 3'd4;

    localparam logic [4:0] REG_IERA  = 5'd3;
    localparam logic [4:0] REG_IERB  = 5'd4;
    localparam logic [4:0] REG_IPRA  = 5'd5;
    localparam logic [4:0] REG_IPRB  = 5'd6;
    localparam logic [4:0] REG_ISRA  = 5'd7;
    localparam logic [4:0] REG_ISRB  = 5'd8;
    localparam logic [4:0] REG_IMRA  = 5'd9;
    localparam logic [4:0] REG_IMRB  = 5'd10;
    localparam logic [4:0] REG_VR    = 5'd11;
    localparam logic [4:0] REG_TACR  = 5'd12;
    localparam logic [4:0] REG_TBCR  = 5'd13;
    localparam logic [4:0] REG_TCDCR = 5'd14;
    localparam logic [4:0] REG_TADR  = 5'd15;
    localparam logic [4:0] REG_TBDR  = 5'd16;
    localparam logic [4:0] REG_TCDR  = 5'd17;
    localparam logic [4:0] REG_TDDR  = 5'd18;
    localparam logic [4:0] REG_TSR   = 5'd22;
    localparam logic [4:0] REG_UDR   = 5'd23;

    localparam logic [5:0] ADDR_LAST    = 6'h2f;
    localparam logic [7:0] TSR_FORCE    = 8'h80;
    localparam logic [7:0] VR_HIGH_MASK = 8'hf0;
    localparam logic [3:0] ACK_LEVEL    = 4'd6;

    localparam logic [3:0] SRC_TIMER_A = 4'd2;
    localparam logic [3:0] SRC_TIMER_B = 4'd7;
    localparam logic [3:0] SRC_TIMER_C = 4'd10;
    localparam logic [3:0] SRC_TIMER_D = 4'd11;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  addr_offset;
        logic [7:0]  write_data;
        logic [3:0]  line_number;
        logic [11:0] clock_count;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] vector;
        logic       vector_valid;
        logic       irq_line;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_T_CHECK,
        ST_DIV1,
        ST_DIV2,
        ST_T_NEXT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic timer_clear;
        logic timer_inc;
        logic div_first;
        logic apply_first;
        logic apply_second;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_advance;
        logic timer_on;
        logic div_done;
        logic wrap;
        logic last_timer;
        logic out_free;
    } t_status;

    function automatic logic [8:0] prescale_period(input logic [2:0] sel);
        logic [8:0] p;
        case (sel)
            3'd0:    p = 9'd1;
            3'd1:    p = 9'd10;
            3'd2:    p = 9'd25;
            3'd3:    p = 9'd40;
            3'd4:    p = 9'd125;
            3'd5:    p = 9'd160;
            3'd6:    p = 9'd250;
            default: p = 9'd500;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] reset_byte(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:    v = 8'h7b;
            5'd1:    v = 8'h06;
            5'd3:    v = 8'h18;
            5'd4:    v = 8'h3e;
            5'd9:    v = 8'h18;
            5'd10:   v = 8'h3e;
            5'd11:   v = 8'h40;
            5'd12:   v = 8'h08;
            5'd13:   v = 8'h01;
            5'd14:   v = 8'h77;
            5'd15:   v = 8'h01;
            5'd16:   v = 8'h0d;
            5'd17:   v = 8'hc8;
            5'd18:   v = 8'h14;
            5'd20:   v = 8'h88;
            5'd21:   v = 8'h01;
            5'd22:   v = 8'h81;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/mitu_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module mitu_divider
    import mitu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic [DIVISOR_W-1:0]  o_remainder
);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVISOR_W:0]    rem_sh;
    logic                  fits;

    assign rem_sh = {r_rem, r_quo[DIVIDEND_W-1]};
    assign fits   = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
            r_rem <= fits ? DIVISOR_W'(rem_sh - {1'b0, r_div}) : rem_sh[DIVISOR_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

FILE: rtl/mitu_ctrl.sv
// Sequencing state machine for item decode, the timer walk and result delivery.
module mitu_ctrl
    import mitu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_status.is_advance) begin
                    o_cmd.timer_clear = 1'b1;
                    n_state           = ST_T_CHECK;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_OUT;
                end
            end
            ST_T_CHECK: begin
                if (i_status.timer_on) begin
                    o_cmd.div_first = 1'b1;
                    n_state         = ST_DIV1;
                end else begin
                    n_state = ST_T_NEXT;
                end
            end
            ST_DIV1: begin
                if (i_status.div_done) begin
                    o_cmd.apply_first = 1'b1;
                    n_state           = i_status.wrap ? ST_DIV2 : ST_T_NEXT;
                end
            end
            ST_DIV2: begin
                if (i_status.div_done) begin
                    o_cmd.apply_second = 1'b1;
                    n_state            = ST_T_NEXT;
                end
            end
            ST_T_NEXT: begin
                if (i_status.last_timer) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.timer_inc = 1'b1;
                    n_state         = ST_T_CHECK;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/mitu_datapath.sv
// Register file, interrupt logic, timer update arithmetic and the output register.
module mitu_datapath
    import mitu_pkg::*;
#(
    parameter int CLOCK_STEP_MAX = CLOCK_STEP_MAX_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  logic      i_out_ready,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    logic [7:0]           r_regs   [REG_COUNT];
    logic [7:0]           n_regs   [REG_COUNT];
    logic [7:0]           r_reload [4];
    logic [7:0]           n_reload [4];
    logic [DIVISOR_W-1:0] r_acc    [4];
    logic [DIVISOR_W-1:0] n_acc    [4];
    logic [1:0]           r_tidx;
    t_in_item             r_item;
    logic [7:0]           r_rdata;
    logic [7:0]           r_vec;
    logic                 r_vvalid;
    logic [7:0]           n_rdata;
    logic [7:0]           n_vec;
    logic                 n_vvalid;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                  timer_on;
    logic [2:0]            timer_sel;
    logic [3:0]            timer_src;
    logic [4:0]            dreg;
    logic [7:0]            cnt_val;
    logic [7:0]            rel_val;
    logic [8:0]            steps_to_zero;
    logic [8:0]            reload_period;
    logic [11:0]           clocks_sat;
    logic [DIVIDEND_W-1:0] acc_sum;
    logic [DIVIDEND_W-1:0] rest_steps;
    logic                  wrap;
    logic                  div_start;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;
    logic [DIVISOR_W-1:0]  div_rem;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [7:0]            act_a;
    logic [7:0]            act_b;
    logic                  irq_now;
    logic [16:0]           step_max;

    assign step_max = 17'(CLOCK_STEP_MAX);
    assign clocks_sat = ({5'd0, r_item.clock_count} > step_max) ? step_max[11:0]
                                                                : r_item.clock_count;

    // Per-timer control decode.
    always_comb begin
        case (r_tidx)
            2'd0: begin
                timer_on  = !r_regs[REG_TACR][3] && (r_regs[REG_TACR][2:0] != 3'd0);
                timer_sel = r_regs[REG_TACR][2:0];
                timer_src = SRC_TIMER_A;
                dreg      = REG_TADR;
            end
            2'd1: begin
                timer_on  = r_regs[REG_TBCR][2:0] != 3'd0;
                timer_sel = r_regs[REG_TBCR][2:0];
                timer_src = SRC_TIMER_B;
                dreg      = REG_TBDR;
            end
            2'd2: begin
                timer_on  = r_regs[REG_TCDCR][6:4] != 3'd0;
                timer_sel = r_regs[REG_TCDCR][6:4];
                timer_src = SRC_TIMER_C;
                dreg      = REG_TCDR;
            end
            default: begin
                timer_on  = r_regs[REG_TCDCR][2:0] != 3'd0;
                timer_sel = r_regs[REG_TCDCR][2:0];
                timer_src = SRC_TIMER_D;
                dreg      = REG_TDDR;
            end
        endcase
    end

    assign cnt_val       = r_regs[dreg];
    assign rel_val       = r_reload[r_tidx];
    assign steps_to_zero = (cnt_val == 8'd0) ? 9'd256 : {1'b0, cnt_val};
    assign reload_period = (rel_val == 8'd0) ? 9'd256 : {1'b0, rel_val};
    assign acc_sum       = DIVIDEND_W'(r_acc[r_tidx]) + DIVIDEND_W'(clocks_sat);
    assign wrap          = div_quo >= DIVIDEND_W'(steps_to_zero);
    assign rest_steps    = div_quo - DIVIDEND_W'(steps_to_zero);

    assign div_start    = i_cmd.div_first || (i_cmd.apply_first && wrap);
    assign div_dividend = i_cmd.div_first ? acc_sum : rest_steps;
    assign div_divisor  = i_cmd.div_first ? prescale_period(timer_sel) : reload_period;

    mitu_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign act_a   = r_regs[REG_IPRA] & r_regs[REG_IMRA] & ~r_regs[REG_ISRA];
    assign act_b   = r_regs[REG_IPRB] & r_regs[REG_IMRB] & ~r_regs[REG_ISRB];
    assign irq_now = |(act_a | act_b);

    always_comb begin
        logic [4:0] reg_idx;
        logic       half;
        logic [7:0] bitm;
        logic [7:0] act;
        logic       found;
        logic [2:0] pos;
        logic [7:0] d;

        n_regs   = r_regs;
        n_reload = r_reload;
        n_acc    = r_acc;
        n_rdata  = r_rdata;
        n_vec    = r_vec;
        n_vvalid = r_vvalid;
        reg_idx  = r_item.addr_offset[5:1];
        half     = 1'b0;
        bitm     = 8'd0;
        act      = 8'd0;
        found    = 1'b0;
        pos      = 3'd0;
        d        = r_item.write_data;

        if (i_cmd.capture) begin
            n_rdata  = 8'd0;
            n_vec    = 8'd0;
            n_vvalid = 1'b0;
        end

        if (i_cmd.exec) begin
            case (r_item.kind)
                KIND_READ: begin
                    if (r_item.addr_offset <= ADDR_LAST) begin
                        n_rdata = r_item.addr_offset[0] ? r_regs[reg_idx] : 8'hff;
                    end
                end
                KIND_WRITE: begin
                    if (r_item.addr_offset <= ADDR_LAST && r_item.addr_offset[0]) begin
                        case (reg_idx)
                            REG_IERA, REG_IERB: begin
                                n_regs[reg_idx]        = d;
                                n_regs[reg_idx + 5'd2] = r_regs[reg_idx + 5'd2] & d;
                            end
                            REG_IPRA, REG_IPRB, REG_ISRA, REG_ISRB: begin
                                n_regs[reg_idx] = r_regs[reg_idx] & d;
                            end
                            REG_TSR: begin
                                n_regs[reg_idx] = d | TSR_FORCE;
                            end
                            REG_TADR, REG_TBDR, REG_TCDR, REG_TDDR: begin
                                n_regs[reg_idx]                  = d;
                                n_reload[2'(reg_idx - REG_TADR)] = d;
                            end
                            REG_UDR: begin
                            end
                            default: begin
                                n_regs[reg_idx] = d;
                            end
                        endcase
                    end
                end
                KIND_REQUEST: begin
                    half = r_item.line_number[3];
                    bitm = 8'h80 >> r_item.line_number[2:0];
                    if ((r_regs[REG_IERA + 5'(half)] & bitm) != 8'd0) begin
                        n_regs[REG_IPRA + 5'(half)] = r_regs[REG_IPRA + 5'(half)] | bitm;
                    end
                end
                KIND_ACK: begin
                    if (r_item.line_number == ACK_LEVEL) begin
                        // Group A holds the higher priorities; its top bit wins first.
                        half = (act_a == 8'd0);
                        act  = half ? act_b : act_a;
                        for (int k = 0; k < 8; k++) begin
                            if (act[k]) begin
                                found = 1'b1;
                                pos   = 3'(k);
                            end
                        end
                        if (found) begin
                            bitm = 8'd1 << pos;
                            n_regs[REG_IPRA + 5'(half)] = r_regs[REG_IPRA + 5'(half)] & ~bitm;
                            if (r_regs[REG_VR][3]) begin
                                n_regs[REG_ISRA + 5'(half)] =
                                    r_regs[REG_ISRA + 5'(half)] | bitm;
                            end
                            n_vec    = (r_regs[REG_VR] & VR_HIGH_MASK) |
                                       {4'd0, !half, pos};
                            n_vvalid = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.apply_first) begin
            n_acc[r_tidx] = div_rem;
            if (!wrap) begin
                n_regs[dreg] = cnt_val - div_quo[7:0];
            end
        end

        if (i_cmd.apply_second) begin
            n_regs[dreg] = rel_val - div_rem[7:0];
            half = timer_src[3];
            bitm = 8'h80 >> timer_src[2:0];
            if ((r_regs[REG_IERA + 5'(half)] & bitm) != 8'd0) begin
                n_regs[REG_IPRA + 5'(half)] = r_regs[REG_IPRA + 5'(half)] | bitm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++) begin
                r_regs[k] <= reset_byte(5'(k));
            end
            for (int k = 0; k < 4; k++) begin
                r_reload[k] <= 8'd0;
                r_acc[k]    <= '0;
            end
            r_tidx      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_regs   <= n_regs;
            r_reload <= n_reload;
            r_acc    <= n_acc;
            if (i_cmd.timer_clear) begin
                r_tidx <= 2'd0;
            end else if (i_cmd.timer_inc) begin
                r_tidx <= r_tidx + 2'd1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        r_rdata  <= n_rdata;
        r_vec    <= n_vec;
        r_vvalid <= n_vvalid;
        if (i_cmd.load_out) begin
            r_out.read_data    <= r_rdata;
            r_out.vector       <= r_vec;
            r_out.vector_valid <= r_vvalid;
            r_out.irq_line     <= irq_now;
        end
    end

    assign o_status.is_advance = r_item.kind == KIND_ADVANCE;
    assign o_status.timer_on   = timer_on;
    assign o_status.div_done   = div_done;
    assign o_status.wrap       = wrap;
    assign o_status.last_timer = r_tidx == 2'd3;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/multifunction_interrupt_timer_unit.sv
// Top level of the multifunction interrupt controller and four-timer unit.
//
// This block models a 24-byte register window holding a 16-source prioritized
// interrupt controller and four 8-bit down-counting timers. Each input
// transaction is a register read, a register write, a source request, an
// interrupt acknowledge or an advance of a number of clocks, and each one
// produces exactly one output transaction carrying the read byte, the
// acknowledged vector with its valid flag, and the interrupt line level after
// the transaction. The block handles one transaction at a time: reads, writes,
// requests and acknowledges pass from the decode state straight to the output
// state. A clock advance walks the four timers in turn; each running timer
// runs one pass of a 13-step restoring divider that splits its accumulated
// clocks into prescaler periods, plus a second pass when its counter reaches
// zero and the reload period must be folded in; stopped timers are skipped.
// The one divider is shared by all four timers. The output register frees the
// block to take its next transaction as soon as the result has been handed on
// or while it is being taken.
module multifunction_interrupt_timer_unit
    import mitu_pkg::*;
#(
    parameter int CLOCK_STEP_MAX = CLOCK_STEP_MAX_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Command and status traffic between the sequencer and the datapath.
    t_cmd    cmd;
    t_status status;

    mitu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    mitu_datapath #(
        .CLOCK_STEP_MAX (CLOCK_STEP_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: dv/mitu_checker.sv
// Checker for the interrupt and timer unit: watches both channels, predicts and compares.
module mitu_checker
    import mitu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_errors,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  regs [REG_COUNT];
    logic [7:0]  reloads [4];
    logic [12:0] accums [4];
    t_out_item   expected_results [$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = expected_results.size();

    function automatic logic [7:0] active_mask(input int half);
        return regs[REG_IPRA + half] & regs[REG_IMRA + half] & ~regs[REG_ISRA + half];
    endfunction

    function automatic void raise_source(input logic [3:0] src);
        int half;
        logic [7:0] bitmask;
        half = src[3];
        bitmask = 8'h80 >> src[2:0];
        if (regs[REG_IERA + half] & bitmask) regs[REG_IPRA + half] |= bitmask;
    endfunction

    function automatic void step_timer(input int idx, input logic [2:0] sel, input int data_reg,
                                       input logic [3:0] src, input int clocks);
        int period;
        int acc;
        period = prescale_period(sel);
        acc = accums[idx] + clocks;
        while (acc >= period) begin
            acc -= period;
            regs[data_reg] = regs[data_reg] - 8'd1;
            if (regs[data_reg] == 8'd0) begin
                regs[data_reg] = reloads[idx];
                raise_source(src);
            end
        end
        accums[idx] = acc[12:0];
    endfunction

    function automatic void write_register(input logic [4:0] r, input logic [7:0] d);
        case (r)
            REG_IERA, REG_IERB: begin
                regs[r] = d;
                regs[r + 2] &= d;
            end
            REG_IPRA, REG_IPRB, REG_ISRA, REG_ISRB: regs[r] &= d;
            REG_TSR: regs[r] = d | TSR_FORCE;
            REG_TADR, REG_TBDR, REG_TCDR, REG_TDDR: begin
                regs[r] = d;
                reloads[r - REG_TADR] = d;
            end
            REG_UDR: ;
            default: regs[r] = d;
        endcase
    endfunction

    function automatic t_out_item predict_result(input t_in_item it);
        t_out_item res;
        logic [7:0] act;
        logic [7:0] bitmask;
        res = '0;
        case (it.kind)
            KIND_READ:
                if (it.addr_offset <= ADDR_LAST)
                    res.read_data = it.addr_offset[0] ? regs[it.addr_offset[5:1]] : 8'hff;
            KIND_WRITE:
                if (it.addr_offset <= ADDR_LAST && it.addr_offset[0])
                    write_register(it.addr_offset[5:1], it.write_data);
            KIND_REQUEST: raise_source(it.line_number);
            KIND_ACK:
                if (it.line_number == ACK_LEVEL) begin
                    for (int half = 0; half < 2 && !res.vector_valid; half++) begin
                        act = active_mask(half);
                        for (int b = 0; b < 8; b++) begin
                            bitmask = 8'h80 >> b;
                            if (act & bitmask) begin
                                regs[REG_IPRA + half] &= ~bitmask;
                                if (regs[REG_VR][3]) regs[REG_ISRA + half] |= bitmask;
                                res.vector = 8'(((half ? 7 : 15) - b)) |
                                             (regs[REG_VR] & VR_HIGH_MASK);
                                res.vector_valid = 1'b1;
                                break;
                            end
                        end
                    end
                end
            KIND_ADVANCE: begin
                int clocks;
                clocks = (it.clock_count > CLOCK_STEP_MAX_DEFAULT) ?
                         CLOCK_STEP_MAX_DEFAULT : int'(it.clock_count);
                if (!regs[REG_TACR][3] && regs[REG_TACR][2:0] != 0)
                    step_timer(0, regs[REG_TACR][2:0], REG_TADR, SRC_TIMER_A, clocks);
                if (regs[REG_TBCR][2:0] != 0)
                    step_timer(1, regs[REG_TBCR][2:0], REG_TBDR, SRC_TIMER_B, clocks);
                if (regs[REG_TCDCR][6:4] != 0)
                    step_timer(2, regs[REG_TCDCR][6:4], REG_TCDR, SRC_TIMER_C, clocks);
                if (regs[REG_TCDCR][2:0] != 0)
                    step_timer(3, regs[REG_TCDCR][2:0], REG_TDDR, SRC_TIMER_D, clocks);
            end
            default: ;
        endcase
        res.irq_line = |(active_mask(0) | active_mask(1));
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) regs[i] = reset_byte(i[4:0]);
            for (int i = 0; i < 4; i++) begin
                reloads[i] = '0;
                accums[i] = '0;
            end
            expected_results.delete();
            errors = 0;
        end else begin
            if (i_in_valid && i_in_ready) expected_results.push_back(predict_result(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %p", i_out_data);
                end else begin
                    exp_item = expected_results.pop_front();
                    if (exp_item !== i_out_data) begin
                        errors++;
                        if (errors <= 10) $display("mismatch: expected %p, got %p",
                                                   exp_item, i_out_data);
                    end
                end
            end
        end
    end
endmodule

FILE: dv/multifunction_interrupt_timer_unit_tb.sv
// Testbench top: drives transactions into the interrupt and timer unit and reports the verdict.
module multifunction_interrupt_timer_unit_tb;
    import mitu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;
    int        errors;
    int        pending;
    int        cycle_count;
    bit        quiet;       // no idling in the last part of the run
    bit        hold_off;    // long receiver stall to fill the block up

    multifunction_interrupt_timer_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    mitu_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_errors(errors), .o_pending(pending)
    );

    // Free-running 4 ns clock.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: the slowest correct run (advances, idle bursts and stalls
    // included) stays far below this bound.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("multifunction_interrupt_timer_unit_tb: errors");
            $finish;
        end
    end

    // The receiver stalls in random bursts, except during the hold-off or the
    // quiet tail of the run. While held off, out_ready stays low for a long stretch.
    initial begin
        int hold_cycles;
        out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                out_ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < 300; hold_cycles++) @(posedge i_clk);
                hold_off = 1'b0;
                out_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offers one transaction and waits for its acceptance. The valid stays high
    // across back-to-back transactions; it only drops for a sender idle burst.
    task automatic send_item(input t_in_item it);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
    endtask

    function automatic t_in_item make_item(input logic [2:0] k, input logic [5:0] a,
                                           input logic [7:0] d, input logic [3:0] n,
                                           input logic [11:0] c);
        t_in_item it;
        it.kind = k;
        it.addr_offset = a;
        it.write_data = d;
        it.line_number = n;
        it.clock_count = c;
        return it;
    endfunction

    // Register write to register r at its odd byte offset.
    function automatic t_in_item reg_write(input logic [4:0] r, input logic [7:0] d);
        return make_item(KIND_WRITE, {r, 1'b1}, d, 4'($urandom), 12'($urandom));
    endfunction

    // Random transaction, weighted toward the interrupt and timer paths that
    // carry most of the behavior.
    function automatic t_in_item random_item();
        t_in_item it;
        int pick;
        it = t_in_item'($bits(t_in_item)'({$urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            it.kind = KIND_READ;
        end else if (pick < 45) begin
            it.kind = KIND_WRITE;
            // Mostly the interrupt and timer registers, sometimes anywhere.
            if ($urandom_range(0, 3) != 0)
                it.addr_offset = {5'($urandom_range(REG_IERA, REG_TDDR)), 1'b1};
        end else if (pick < 60) begin
            it.kind = KIND_REQUEST;
        end else if (pick < 78) begin
            it.kind = KIND_ACK;
            if ($urandom_range(0, 4) != 0) it.line_number = ACK_LEVEL;
        end else if (pick < 97) begin
            it.kind = KIND_ADVANCE;
            if ($urandom_range(0, 3) != 0) it.clock_count = 12'($urandom_range(0, 300));
        end else begin
            it.kind = 3'($urandom_range(5, 7));
        end
        return it;
    endfunction

    initial begin
        in_valid = 1'b0;
        in_data  = '0;
        quiet    = 1'b0;
        hold_off = 1'b0;
        i_rst_n  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset values, odd offsets, enables, timers, acknowledges.
        send_item(make_item(KIND_READ, 6'h00, 8'h00, 4'd0, 12'd0));     // even offset
        send_item(make_item(KIND_READ, 6'h3f, 8'hff, 4'hf, 12'hfff));   // above window
        send_item(make_item(KIND_READ, 6'h2d, 8'h00, 4'd0, 12'd0));     // TSR
        send_item(make_item(KIND_WRITE, 6'h30, 8'hff, 4'd0, 12'd0));    // ignored
        send_item(make_item(KIND_WRITE, 6'h06, 8'hff, 4'd0, 12'd0));    // even, ignored
        send_item(reg_write(REG_TSR, 8'h00));                            // bit 7 forced
        send_item(reg_write(REG_UDR, 8'h55));                            // dropped
        send_item(reg_write(REG_IERA, 8'hff));
        send_item(reg_write(REG_IERB, 8'hff));
        send_item(reg_write(REG_IMRA, 8'hff));
        send_item(reg_write(REG_IMRB, 8'hff));
        send_item(make_item(KIND_REQUEST, 6'h00, 8'h00, 4'd15, 12'd0));
        send_item(make_item(KIND_REQUEST, 6'h00, 8'h00, 4'd0, 12'd0));
        send_item(make_item(KIND_ACK, 6'h00, 8'h00, 4'd5, 12'd0));      // wrong level
        send_item(reg_write(REG_VR, 8'hf8));                             // in-service mode
        send_item(make_item(KIND_ACK, 6'h00, 8'h00, ACK_LEVEL, 12'd0));
        send_item(make_item(KIND_ACK, 6'h00, 8'h00, ACK_LEVEL, 12'd0));
        send_item(make_item(KIND_ACK, 6'h00, 8'h00, ACK_LEVEL, 12'd0)); // none left
        send_item(reg_write(REG_TADR, 8'h00));                           // period 256
        send_item(reg_write(REG_TACR, 8'h0f));                           // event mode
        send_item(make_item(KIND_ADVANCE, 6'h00, 8'h00, 4'd0, 12'hfff));
        send_item(reg_write(REG_TACR, 8'h01));
        send_item(reg_write(REG_TCDCR, 8'h17));
        send_item(make_item(KIND_ADVANCE, 6'h00, 8'h00, 4'd0, 12'hfff));
        send_item(make_item(KIND_ADVANCE, 6'h00, 8'h00, 4'd0, 12'd0));

        // Random part, with one long receiver hold-off early on.
        for (int n = 0; n < 700; n++) begin
            if (n == 50) hold_off = 1'b1;
            if (n == 600) quiet = 1'b1;
            send_item(random_item());
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (errors == 0) begin
            $display("multifunction_interrupt_timer_unit_tb: clean");
        end else begin
            $display("multifunction_interrupt_timer_unit_tb: errors");
        end
        $finish;
    end
endmodule

FILE: multifunction_interrupt_timer_unit.f
rtl/mitu_pkg.sv
rtl/mitu_divider.sv
rtl/mitu_ctrl.sv
rtl/mitu_datapath.sv
rtl/multifunction_interrupt_timer_unit.sv
dv/mitu_checker.sv
dv/multifunction_interrupt_timer_unit_tb.sv
